>>> rtl/tcps_pkg.sv
package tcps_pkg;

   localparam int PRIO_DEPTH = 16;
   localparam int REG_DEPTH  = 16;
   localparam int ID_BITS    = 16;

   localparam int SEV_W   = 4;
   localparam int MIN_W   = 10;
   localparam int PCNT_W  = $clog2(PRIO_DEPTH + 1);
   localparam int FCNT_W  = $clog2(REG_DEPTH + 1);
   localparam int PTR_W   = $clog2(REG_DEPTH);
   localparam int TOT_W   = $clog2(PRIO_DEPTH + REG_DEPTH + 1);
   localparam int PROD_W  = TOT_W + MIN_W;

   localparam logic [SEV_W-1:0]   SEV_MAX       = SEV_W'(10);
   localparam logic [MIN_W-1:0]   MINUTES_RESET = MIN_W'(10);
   localparam logic [ID_BITS-1:0] ID_RESET      = ID_BITS'(1);
   localparam logic [14:0]        WAIT_MAX      = 15'h7FFF;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_SERVE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED       = 3'd0,
      ST_SERVED_PRIO = 3'd1,
      ST_SERVED_REG  = 3'd2,
      ST_NONE        = 3'd3,
      ST_REJECTED    = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type          command;
      logic [SEV_W-1:0] severity;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [15:0]      item_id;
      logic [SEV_W-1:0] served_severity;
      logic [5:0]       waiting_count;
      logic [14:0]      estimated_wait;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [SEV_W-1:0]   sev;
      logic [ID_BITS-1:0] id;
   } entry_type;

   typedef struct packed {
      logic               ins;
      logic               rem;
      logic [SEV_W-1:0]   sev;
      logic [ID_BITS-1:0] id;
   } chain_ctl_type;

   typedef struct packed {
      logic      full;
      logic      empty;
      entry_type head;
   } chain_stat_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [ID_BITS-1:0] wr_id;
   } fifo_ctl_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [FCNT_W-1:0] fill;
   } fifo_stat_type;

endpackage

>>> rtl/tcps_cell.sv
module tcps_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tcps_pkg::chain_ctl_type ctl,
   input  tcps_pkg::entry_type     left_entry,
   input  logic                    left_keep,
   input  tcps_pkg::entry_type     right_entry,
   output tcps_pkg::entry_type     entry,
   output logic                    keep
);

   tcps_pkg::entry_type entry_ff;
   tcps_pkg::entry_type entry_in;

   // hold on insert when this entry ranks at or above the new one (earlier wins ties)
   assign keep = entry_ff.valid && (entry_ff.sev >= ctl.sev);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in.valid = 1'b1;
               entry_in.sev   = ctl.sev;
               entry_in.id    = ctl.id;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctl.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.sev <= entry_in.sev;
      entry_ff.id  <= entry_in.id;
   end

   assign entry = entry_ff;

endmodule

>>> rtl/tcps_chain.sv
module tcps_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  tcps_pkg::chain_ctl_type  ctl,
   output tcps_pkg::chain_stat_type stat
);

   localparam int N = tcps_pkg::PRIO_DEPTH;

   tcps_pkg::entry_type entries [N];
   tcps_pkg::entry_type lefts   [N];
   tcps_pkg::entry_type rights  [N];
   logic                keeps   [N];
   logic                lkeeps  [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign lefts[g]  = '0;
            assign lkeeps[g] = 1'b1;
         end else begin : g_mid
            assign lefts[g]  = entries[g-1];
            assign lkeeps[g] = keeps[g-1];
         end
         if (g == N - 1) begin : g_last
            assign rights[g] = '0;
         end else begin : g_inner
            assign rights[g] = entries[g+1];
         end

         tcps_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_entry  (lefts[g]),
            .left_keep   (lkeeps[g]),
            .right_entry (rights[g]),
            .entry       (entries[g]),
            .keep        (keeps[g])
         );
      end
   endgenerate

   // valid cells always form a prefix of the row
   assign stat.head  = entries[0];
   assign stat.empty = !entries[0].valid;
   assign stat.full  = entries[N-1].valid;

endmodule

>>> rtl/tcps_fifo.sv
module tcps_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  tcps_pkg::fifo_ctl_type          ctl,
   output tcps_pkg::fifo_stat_type         stat,
   output logic [tcps_pkg::ID_BITS-1:0]    rd_data
);

   localparam int PW = tcps_pkg::PTR_W;
   localparam int CW = tcps_pkg::FCNT_W;

   logic [tcps_pkg::ID_BITS-1:0] mem [tcps_pkg::REG_DEPTH];
   logic [tcps_pkg::ID_BITS-1:0] rd_data_ff;
   logic [PW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]                wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]                fill_ff, fill_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(tcps_pkg::REG_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   always_comb begin
      rd_ptr_in = ctl.pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = ctl.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      fill_in   = fill_ff + CW'(ctl.push) - CW'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= ctl.wr_id;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign stat.fill  = fill_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == CW'(tcps_pkg::REG_DEPTH));
   assign rd_data    = rd_data_ff;

endmodule

>>> rtl/two_class_priority_scheduler.sv
// Two-class scheduler: priority adds (severity 1 to 10, above 10 counts as
// 10) enter a sorted chain of cells, highest severity first and the earlier
// arrival first among equals; severity-0 adds enter a plain FIFO. A serve
// takes the chain head, or the FIFO head only when the chain is empty.
// Timing: a request is taken at any edge with start high; busy is always low,
// so one request per cycle is sustained. Its result is on rsp_data with
// rsp_strobe high in the cycle right after, for exactly one cycle; the
// receiver cannot stall, so capture it then. The request rate is set by
// the cell row, where a cell moves at most one place (insert or serve) at the
// same edge, and by the single registered FIFO memory read. No clearing pass
// after reset. Write the minutes register over csr_valid/csr_data (csr_ready
// is always high) only while no result is pending.
module two_class_priority_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tcps_pkg::req_type                    req_data,
   output logic                                 rsp_strobe,
   output tcps_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcps_pkg::MIN_W-1:0]           csr_data
);

   localparam int SW = tcps_pkg::SEV_W;
   localparam int PC = tcps_pkg::PCNT_W;
   localparam int TW = tcps_pkg::TOT_W;

   tcps_pkg::chain_ctl_type  chain_ctl;
   tcps_pkg::chain_stat_type chain_stat;
   tcps_pkg::fifo_ctl_type   fifo_ctl;
   tcps_pkg::fifo_stat_type  fifo_stat;
   logic [tcps_pkg::ID_BITS-1:0] fifo_rd_data;

   // configuration and counters
   logic [tcps_pkg::MIN_W-1:0]   minutes_ff;
   logic [tcps_pkg::ID_BITS-1:0] next_id_ff, next_id_in;
   logic [PC-1:0]                pcnt_ff, pcnt_in;

   // result registers
   logic                         rsp_valid_ff;
   tcps_pkg::status_type         status_ff, status_in;
   logic [15:0]                  id_ff, id_in;
   logic [SW-1:0]                sev_ff, sev_in;
   logic [5:0]                   count_ff;
   logic [14:0]                  wait_ff, wait_in;
   logic                         sel_fifo_ff;

   logic                         accept;
   logic [SW-1:0]                sev_sat;
   logic                         is_add, prio_add, reg_add, serve;
   logic [tcps_pkg::FCNT_W-1:0]  fill_in;
   logic [TW-1:0]                total;
   logic [tcps_pkg::PROD_W-1:0]  prod;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   tcps_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (chain_ctl),
      .stat  (chain_stat)
   );

   tcps_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .stat    (fifo_stat),
      .rd_data (fifo_rd_data)
   );

   always_comb begin
      // clamp severity, then split the request by class
      sev_sat  = (req_data.severity > tcps_pkg::SEV_MAX) ? tcps_pkg::SEV_MAX
                                                        : req_data.severity;
      is_add   = (req_data.command == tcps_pkg::CMD_ADD);
      prio_add = accept && is_add && (sev_sat != '0);
      reg_add  = accept && is_add && (sev_sat == '0);
      serve    = accept && !is_add;

      chain_ctl.ins = prio_add && !chain_stat.full;
      chain_ctl.rem = serve && !chain_stat.empty;
      chain_ctl.sev = sev_sat;
      chain_ctl.id  = next_id_ff;

      fifo_ctl.push  = reg_add && !fifo_stat.full;
      fifo_ctl.pop   = serve && chain_stat.empty && !fifo_stat.empty;
      fifo_ctl.wr_id = next_id_ff;

      // advance the identifier only on a stored add
      next_id_in = (chain_ctl.ins || fifo_ctl.push) ? next_id_ff + tcps_pkg::ID_BITS'(1)
                                                   : next_id_ff;

      pcnt_in = pcnt_ff + PC'(chain_ctl.ins) - PC'(chain_ctl.rem);
      fill_in = fifo_stat.fill + tcps_pkg::FCNT_W'(fifo_ctl.push)
                               - tcps_pkg::FCNT_W'(fifo_ctl.pop);

      status_in = tcps_pkg::ST_NONE;
      id_in     = '0;
      sev_in    = '0;
      priority if (chain_ctl.ins || fifo_ctl.push) begin
         status_in = tcps_pkg::ST_ADDED;
         id_in     = 16'(next_id_ff);
      end else if (is_add) begin
         status_in = tcps_pkg::ST_REJECTED;
      end else if (chain_ctl.rem) begin
         status_in = tcps_pkg::ST_SERVED_PRIO;
         id_in     = 16'(chain_stat.head.id);
         sev_in    = chain_stat.head.sev;
      end else if (fifo_ctl.pop) begin
         status_in = tcps_pkg::ST_SERVED_REG;
      end else begin
         status_in = tcps_pkg::ST_NONE;
      end

      // waiting count after this step, times minutes per item, saturated
      total   = TW'(pcnt_in) + TW'(fill_in);
      prod    = tcps_pkg::PROD_W'(total) * tcps_pkg::PROD_W'(minutes_ff);
      wait_in = (prod > tcps_pkg::PROD_W'(tcps_pkg::WAIT_MAX)) ? tcps_pkg::WAIT_MAX
                                                              : 15'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minutes_ff   <= tcps_pkg::MINUTES_RESET;
         next_id_ff   <= tcps_pkg::ID_RESET;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            minutes_ff <= csr_data;
         end
         next_id_ff   <= next_id_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= accept;
      end
   end

   // hold result payload from the accepting edge until the next request
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         id_ff       <= id_in;
         sev_ff      <= sev_in;
         count_ff    <= 6'(total);
         wait_ff     <= wait_in;
         sel_fifo_ff <= fifo_ctl.pop;
      end
   end

   // a regular serve takes its identifier from the registered FIFO read
   assign rsp_strobe               = rsp_valid_ff;
   assign rsp_data.status          = status_ff;
   assign rsp_data.item_id         = sel_fifo_ff ? 16'(fifo_rd_data) : id_ff;
   assign rsp_data.served_severity = sev_ff;
   assign rsp_data.waiting_count   = count_ff;
   assign rsp_data.estimated_wait  = wait_ff;

`ifndef SYNTH
   a_count_tracks_head: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff != '0) == chain_stat.head.valid)
      else $error("priority count disagrees with chain head");

   a_full_tracks_count: assert property (@(posedge clock) disable iff (reset)
      chain_stat.full == (pcnt_ff == PC'(tcps_pkg::PRIO_DEPTH)))
      else $error("chain full flag disagrees with count");

   a_strobe_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request produced no result");

   a_no_spurious_strobe: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without a request");

   a_prio_serve_sev: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == tcps_pkg::ST_SERVED_PRIO) |->
      (rsp_data.served_severity != '0 && rsp_data.served_severity <= tcps_pkg::SEV_MAX))
      else $error("served priority item with bad severity");
`endif

endmodule

>>> test/scheduler_checker.sv
`timescale 1ns / 1ps
module scheduler_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  tcps_pkg::req_type          req_data,
   input  logic                       rsp_strobe,
   input  tcps_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [tcps_pkg::MIN_W-1:0] csr_data,
   output int                         mismatch_count,
   output int                         results_pending
);

   // ranked class: sorted by severity, highest first, arrival order within one
   logic [tcps_pkg::SEV_W-1:0]   ranked_sev [tcps_pkg::PRIO_DEPTH];
   logic [tcps_pkg::ID_BITS-1:0] ranked_id  [tcps_pkg::PRIO_DEPTH];
   int                           ranked_count;
   logic [tcps_pkg::ID_BITS-1:0] regular_ids [$];
   logic [tcps_pkg::ID_BITS-1:0] id_counter;
   logic [tcps_pkg::MIN_W-1:0]   minutes;
   tcps_pkg::rsp_type            outcome_queue [$];

   function automatic tcps_pkg::rsp_type schedule_outcome(input tcps_pkg::req_type r);
      tcps_pkg::rsp_type          o;
      logic [tcps_pkg::SEV_W-1:0] s;
      int                         pos;
      int                         total;
      int                         product;
      o = '0;
      s = (r.severity > tcps_pkg::SEV_MAX) ? tcps_pkg::SEV_MAX : r.severity;
      if (r.command == tcps_pkg::CMD_ADD) begin
         if ((s != 0 && ranked_count >= tcps_pkg::PRIO_DEPTH) ||
             (s == 0 && regular_ids.size() >= tcps_pkg::REG_DEPTH)) begin
            o.status = tcps_pkg::ST_REJECTED;
         end else begin
            o.status  = tcps_pkg::ST_ADDED;
            o.item_id = id_counter;
            if (s != 0) begin
               pos = 0;
               while (pos < ranked_count && ranked_sev[pos] >= s) pos++;
               for (int i = ranked_count; i > pos; i--) begin
                  ranked_sev[i] = ranked_sev[i-1];
                  ranked_id[i]  = ranked_id[i-1];
               end
               ranked_sev[pos] = s;
               ranked_id[pos]  = id_counter;
               ranked_count++;
            end else begin
               regular_ids.insert(regular_ids.size(), id_counter);
            end
            id_counter++;
         end
      end else if (ranked_count > 0) begin
         o.status          = tcps_pkg::ST_SERVED_PRIO;
         o.item_id         = ranked_id[0];
         o.served_severity = ranked_sev[0];
         for (int i = 0; i + 1 < ranked_count; i++) begin
            ranked_sev[i] = ranked_sev[i+1];
            ranked_id[i]  = ranked_id[i+1];
         end
         ranked_count--;
      end else if (regular_ids.size() > 0) begin
         o.status  = tcps_pkg::ST_SERVED_REG;
         o.item_id = regular_ids.pop_front();
      end else begin
         o.status = tcps_pkg::ST_NONE;
      end
      total            = ranked_count + regular_ids.size();
      product          = total * minutes;
      o.waiting_count  = 6'(total);
      o.estimated_wait = (product > 32'h7FFF) ? tcps_pkg::WAIT_MAX : 15'(product);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      tcps_pkg::rsp_type want;
      if (reset) begin
         ranked_count = 0;
         regular_ids.delete();
         outcome_queue.delete();
         id_counter = tcps_pkg::ID_RESET;
         minutes    = tcps_pkg::MINUTES_RESET;
         results_pending <= 0;
      end else begin
         if (csr_valid && csr_ready) minutes = csr_data;
         if (start && !busy)
            outcome_queue.insert(outcome_queue.size(), schedule_outcome(req_data));
         if (rsp_strobe) begin
            if (outcome_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with none expected: status %0d id %0d sev %0d",
                           $time, rsp_data.status, rsp_data.item_id,
                           rsp_data.served_severity);
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.item_id !== want.item_id ||
                   rsp_data.served_severity !== want.served_severity ||
                   rsp_data.waiting_count !== want.waiting_count ||
                   rsp_data.estimated_wait !== want.estimated_wait) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: mismatch: expected status %0d id %0d sev %0d ",
                            $time, want.status, want.item_id, want.served_severity);
                     $write("count %0d wait %0d, ",
                            want.waiting_count, want.estimated_wait);
                     $write("got status %0d id %0d sev %0d ",
                            rsp_data.status, rsp_data.item_id,
                            rsp_data.served_severity);
                     $display("count %0d wait %0d",
                              rsp_data.waiting_count, rsp_data.estimated_wait);
                  end
               end
            end
         end
         results_pending <= outcome_queue.size();
      end
   end

endmodule

>>> test/tb_two_class_priority_scheduler.sv
`timescale 1ns / 1ps
module tb_two_class_priority_scheduler;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       busy;
   tcps_pkg::req_type          req_data  = '0;
   logic                       rsp_strobe;
   tcps_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [tcps_pkg::MIN_W-1:0] csr_data  = '0;
   int                         mismatch_count;
   int                         results_pending;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   two_class_priority_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Watches all three channels, predicts every result and compares.
   scheduler_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // Present one request and hold it until the transfer happens. Start stays
   // high on return so back-to-back requests need no idle gap between them.
   task automatic issue(input tcps_pkg::cmd_type c,
                        input logic [tcps_pkg::SEV_W-1:0] s);
      tcps_pkg::req_type r;
      r.command  = c;
      r.severity = s;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a random stretch; the chance per cycle is idle_pct.
   task automatic pace(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Stop sending and wait until every predicted result has been seen.
   // The pending count is registered, so always advance at least once.
   task automatic settle;
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write the minutes register, only with the block idle.
   task automatic set_minutes(input logic [tcps_pkg::MIN_W-1:0] m);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly legal priorities, some regular, some above the top level.
   function automatic logic [tcps_pkg::SEV_W-1:0] pick_severity;
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return tcps_pkg::SEV_W'(0);
      if (roll < 30) return tcps_pkg::SEV_W'($urandom_range(15, 11));
      return tcps_pkg::SEV_W'($urandom_range(10, 1));
   endfunction

   // Bursts of adds (mixed or regular only) and bursts of serves, long enough
   // to hit a full class and an empty scheduler; one in ten commands is noise.
   task automatic run_traffic(input int items, input int idle_pct);
      int                sent;
      int                burst;
      int                mode;
      tcps_pkg::cmd_type c;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(24, 1);
         mode  = $urandom_range(2);
         repeat (burst) begin
            if ($urandom_range(9) == 0) c = tcps_pkg::cmd_type'($urandom_range(1));
            else c = (mode == 2) ? tcps_pkg::CMD_SERVE : tcps_pkg::CMD_ADD;
            pace(idle_pct);
            issue(c, (mode == 1) ? tcps_pkg::SEV_W'(0) : pick_severity());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, minutes still at the reset value.
      issue(tcps_pkg::CMD_SERVE, tcps_pkg::SEV_W'(0));   // nothing waiting
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(0));     // regular class
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(15));    // saturates to the top level
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(11));
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(1));
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(10));
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(5));
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(5));     // tie, earlier arrival goes first
      issue(tcps_pkg::CMD_ADD, tcps_pkg::SEV_W'(0));
      // drain priority in order, then the regular class, then empty again
      repeat (9) issue(tcps_pkg::CMD_SERVE, tcps_pkg::SEV_W'(15));

      // Random part across minutes settings and idle profiles.
      set_minutes(tcps_pkg::MIN_W'(1023));
      run_traffic(450, 0);
      set_minutes(tcps_pkg::MIN_W'(1));
      run_traffic(450, 64);
      set_minutes(tcps_pkg::MIN_W'(0));
      run_traffic(300, 7);
      set_minutes(tcps_pkg::MIN_W'($urandom_range(1022, 2)));
      run_traffic(400, 64);
      set_minutes(tcps_pkg::MIN_W'(1023));
      run_traffic(200, 7);

      settle();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hang guard, far above the slowest legal run.
   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
rtl/tcps_pkg.sv
rtl/tcps_cell.sv
rtl/tcps_chain.sv
rtl/tcps_fifo.sv
rtl/two_class_priority_scheduler.sv
test/scheduler_checker.sv
test/tb_two_class_priority_scheduler.sv
